>>> hdl/mbe_pkg.sv
// Shared types, constants, microcode program and helpers of the Mandelbrot escape-time engine.
// Used by mbe_seq, mbe_datapath and mandelbrot_escape_time_top; depends on nothing else.
package mbe_pkg;

	// Field and register widths.
	localparam int IDX_W       = 12;
	localparam int MAX_ITER_W  = 16;
	localparam int COORD_W     = 32;
	localparam int STEP_W      = 31;
	localparam int PAL_OFF_W   = 8;
	localparam int PAL_IDX_W   = 8;
	localparam int PROD_W      = 2 * COORD_W;
	localparam int PCOORD_W    = IDX_W + STEP_W;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 32;

	// Number of palette entries; a power of two, so the modulo is a mask.
	localparam int PALETTE_SIZE = 16;

	// Default number of fraction bits of the fixed-point coordinates.
	localparam int FRAC_BITS_DEF = 28;

	// Register reset values.
	localparam logic [MAX_ITER_W-1:0] RST_MAX_ITER  = 16'd256;
	localparam logic [COORD_W-1:0]    RST_VIEW_LEFT = 32'hE000_0000;
	localparam logic [COORD_W-1:0]    RST_VIEW_TOP  = 32'h1000_0000;
	localparam logic [STEP_W-1:0]     RST_STEP      = 31'h0004_0000;
	localparam logic [PAL_OFF_W-1:0]  RST_PAL_OFF   = 8'd0;

	// Saturation bounds of a coordinate, held in product width.
	localparam logic signed [PROD_W-1:0] SAT_HI = (64'sd1 <<< (COORD_W - 1)) - 64'sd1;
	localparam logic signed [PROD_W-1:0] SAT_LO = -(64'sd1 <<< (COORD_W - 1));

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAX_ITER  = 3'd0,
		REG_VIEW_LEFT = 3'd1,
		REG_VIEW_TOP  = 3'd2,
		REG_STEP_REAL = 3'd3,
		REG_STEP_IMAG = 3'd4,
		REG_PAL_OFF   = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [MAX_ITER_W-1:0] max_iterations;
		logic [COORD_W-1:0]    view_left;
		logic [COORD_W-1:0]    view_top;
		logic [STEP_W-1:0]     step_real;
		logic [STEP_W-1:0]     step_imag;
		logic [PAL_OFF_W-1:0]  palette_offset;
	} cfg_t;

	typedef struct packed {
		logic [IDX_W-1:0] pixel_row;
		logic [IDX_W-1:0] pixel_col;
	} in_item_t;

	typedef struct packed {
		logic                  inside_set;
		logic [MAX_ITER_W-1:0] iteration_count;
		logic [PAL_IDX_W-1:0]  palette_index;
	} out_item_t;

	// Datapath operations selected by a microcode word.
	typedef enum logic [2:0] {
		OP_NOP,
		OP_CMUL,
		OP_CADD,
		OP_MUL,
		OP_SUM,
		OP_UPD
	} dp_op_t;

	// Branch conditions; when the condition holds the sequencer goes to next_t.
	typedef enum logic [1:0] {
		BR_ALWAYS,
		BR_NO_REQ,
		BR_STOP,
		BR_OUT_BUSY
	} br_cond_t;

	localparam int UPC_W = 4;
	typedef logic [UPC_W-1:0] upc_t;

	typedef struct packed {
		dp_op_t   op;
		logic     take_in;
		logic     load_out;
		br_cond_t cond;
		upc_t     next_t;
		upc_t     next_f;
	} ucode_t;

	// Condition inputs seen by the sequencer.
	typedef struct packed {
		logic no_req;
		logic stop;
		logic out_busy;
	} seq_cond_t;

	// Microcode addresses.
	localparam upc_t UA_IDLE  = 4'd0;
	localparam upc_t UA_CMUL  = 4'd1;
	localparam upc_t UA_CADD  = 4'd2;
	localparam upc_t UA_MUL0  = 4'd3;
	localparam upc_t UA_SUM0  = 4'd4;
	localparam upc_t UA_UPD0  = 4'd5;
	localparam upc_t UA_MUL   = 4'd6;
	localparam upc_t UA_CHK   = 4'd7;
	localparam upc_t UA_UPD   = 4'd8;
	localparam upc_t UA_DONE  = 4'd9;

	// The control program. The first iteration runs without an escape check;
	// each later one is multiply, sum with check, update.
	function automatic ucode_t ucode_rom(input upc_t a);
		ucode_t w;
		case (a)
			UA_IDLE: w = '{op: OP_NOP, take_in: 1'b1, load_out: 1'b0, cond: BR_NO_REQ,
				next_t: UA_IDLE, next_f: UA_CMUL};
			UA_CMUL: w = '{op: OP_CMUL, take_in: 1'b0, load_out: 1'b0, cond: BR_ALWAYS,
				next_t: UA_CADD, next_f: UA_CADD};
			UA_CADD: w = '{op: OP_CADD, take_in: 1'b0, load_out: 1'b0, cond: BR_ALWAYS,
				next_t: UA_MUL0, next_f: UA_MUL0};
			UA_MUL0: w = '{op: OP_MUL, take_in: 1'b0, load_out: 1'b0, cond: BR_ALWAYS,
				next_t: UA_SUM0, next_f: UA_SUM0};
			UA_SUM0: w = '{op: OP_SUM, take_in: 1'b0, load_out: 1'b0, cond: BR_ALWAYS,
				next_t: UA_UPD0, next_f: UA_UPD0};
			UA_UPD0: w = '{op: OP_UPD, take_in: 1'b0, load_out: 1'b0, cond: BR_ALWAYS,
				next_t: UA_MUL, next_f: UA_MUL};
			UA_MUL: w = '{op: OP_MUL, take_in: 1'b0, load_out: 1'b0, cond: BR_ALWAYS,
				next_t: UA_CHK, next_f: UA_CHK};
			UA_CHK: w = '{op: OP_SUM, take_in: 1'b0, load_out: 1'b0, cond: BR_STOP,
				next_t: UA_DONE, next_f: UA_UPD};
			UA_UPD: w = '{op: OP_UPD, take_in: 1'b0, load_out: 1'b0, cond: BR_ALWAYS,
				next_t: UA_MUL, next_f: UA_MUL};
			UA_DONE: w = '{op: OP_NOP, take_in: 1'b0, load_out: 1'b1, cond: BR_OUT_BUSY,
				next_t: UA_DONE, next_f: UA_IDLE};
			default: w = '{op: OP_NOP, take_in: 1'b0, load_out: 1'b0, cond: BR_ALWAYS,
				next_t: UA_IDLE, next_f: UA_IDLE};
		endcase
		return w;
	endfunction

	// Clamp a wide signed value to the coordinate range.
	function automatic logic [COORD_W-1:0] sat_coord(input logic signed [PROD_W-1:0] v);
		logic [COORD_W-1:0] r;
		if (v > SAT_HI) begin
			r = SAT_HI[COORD_W-1:0];
		end else if (v < SAT_LO) begin
			r = SAT_LO[COORD_W-1:0];
		end else begin
			r = v[COORD_W-1:0];
		end
		return r;
	endfunction

endpackage

>>> hdl/mbe_seq.sv
// Microcode sequencer: step counter, control ROM lookup and conditional jumps.
// Depends on mbe_pkg for the control word, conditions and the program.
module mbe_seq
	import mbe_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  seq_cond_t cond,
	output ucode_t    ctl
);

	upc_t upc_q;
	upc_t upc_next;
	logic taken;

	always_comb begin
		ctl = ucode_rom(upc_q);
	end

	always_comb begin
		case (ctl.cond)
			BR_ALWAYS:   taken = 1'b1;
			BR_NO_REQ:   taken = cond.no_req;
			BR_STOP:     taken = cond.stop;
			BR_OUT_BUSY: taken = cond.out_busy;
			default:     taken = 1'b1;
		endcase
		upc_next = taken ? ctl.next_t : ctl.next_f;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= UA_IDLE;
		end else begin
			upc_q <= upc_next;
		end
	end

endmodule

>>> hdl/mbe_datapath.sv
// Fixed-point datapath: point setup, complex square-and-add, escape test and result fields.
// Depends on mbe_pkg; driven one operation per cycle by the microcode word.
module mbe_datapath
	import mbe_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic      clk,
	input  ucode_t    ctl,
	input  logic      in_fire,
	input  in_item_t  in_item,
	input  cfg_t      cfg,
	output logic      stop,
	output out_item_t result
);

	logic [IDX_W-1:0]             row_q;
	logic [IDX_W-1:0]             col_q;
	logic [PCOORD_W-1:0]          pcr_q;
	logic [PCOORD_W-1:0]          pci_q;
	logic signed [COORD_W-1:0]    cr_q;
	logic signed [COORD_W-1:0]    ci_q;
	logic signed [COORD_W-1:0]    zr_q;
	logic signed [COORD_W-1:0]    zi_q;
	logic signed [PROD_W-1:0]     rr_q;
	logic signed [PROD_W-1:0]     ii_q;
	logic signed [PROD_W-1:0]     ri_q;
	logic signed [PROD_W-1:0]     dr_q;
	logic signed [PROD_W-1:0]     di_q;
	logic [MAX_ITER_W-1:0]        k_q;
	logic [PROD_W-1:0]            mag;
	logic                         escaped;
	logic [MAX_ITER_W:0]          pal_sum;

	always_ff @(posedge clk) begin
		if (in_fire) begin
			row_q <= in_item.pixel_row;
			col_q <= in_item.pixel_col;
		end
		case (ctl.op)
			OP_NOP: begin
			end
			OP_CMUL: begin
				pcr_q <= PCOORD_W'(col_q) * PCOORD_W'(cfg.step_real);
				pci_q <= PCOORD_W'(row_q) * PCOORD_W'(cfg.step_imag);
			end
			OP_CADD: begin
				cr_q <= sat_coord(PROD_W'($signed(cfg.view_left))
					+ $signed(PROD_W'(pcr_q)));
				ci_q <= sat_coord(PROD_W'($signed(cfg.view_top))
					- $signed(PROD_W'(pci_q)));
				zr_q <= '0;
				zi_q <= '0;
				k_q  <= '0;
			end
			OP_MUL: begin
				rr_q <= zr_q * zr_q;
				ii_q <= zi_q * zi_q;
				ri_q <= zr_q * zi_q;
			end
			OP_SUM: begin
				// The cross term carries the factor two by shifting one bit less.
				dr_q <= (rr_q - ii_q) >>> FRAC_BITS;
				di_q <= ri_q >>> (FRAC_BITS - 1);
			end
			OP_UPD: begin
				zr_q <= sat_coord(dr_q + PROD_W'(cr_q));
				zi_q <= sat_coord(di_q + PROD_W'(ci_q));
				k_q  <= k_q + 1'b1;
			end
			default: begin
			end
		endcase
	end

	// The squares are never negative, so their sum fits unsigned in product width.
	always_comb begin
		mag     = $unsigned(rr_q) + $unsigned(ii_q);
		escaped = (mag >> FRAC_BITS) >= (PROD_W'(4) << FRAC_BITS);
		stop    = escaped || (k_q >= cfg.max_iterations);
	end

	always_comb begin
		pal_sum                = {1'b0, k_q} + (MAX_ITER_W + 1)'(cfg.palette_offset);
		result.inside_set      = (k_q == cfg.max_iterations);
		result.iteration_count = k_q;
		result.palette_index   = result.inside_set ? '0
			: PAL_IDX_W'(pal_sum % PALETTE_SIZE);
	end

endmodule

>>> hdl/mandelbrot_escape_time_top.sv
// Mandelbrot escape-time engine, top level. One pixel request at a time; the next request
// is taken only after the result of the previous one has been loaded into the output
// register. The iterations run the three-step multiply, sum and update loop of the
// microcode. A finished result waits in the output register. Reset (arst_n, asynchronous,
// active low) loads the default view and limits, parks the sequencer at its idle step
// and empties the output register.
module mandelbrot_escape_time_top
	import mbe_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_item_t             out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t      cfg_q;
	ucode_t    ctl;
	seq_cond_t cond;
	logic      in_fire;
	logic      out_busy;
	logic      out_load;
	logic      dp_stop;
	out_item_t dp_result;
	logic      out_valid_q;
	out_item_t out_data_q;

	// Configuration writes are always taken; an index past the last register is dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_iterations <= RST_MAX_ITER;
			cfg_q.view_left      <= RST_VIEW_LEFT;
			cfg_q.view_top       <= RST_VIEW_TOP;
			cfg_q.step_real      <= RST_STEP;
			cfg_q.step_imag      <= RST_STEP;
			cfg_q.palette_offset <= RST_PAL_OFF;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_MAX_ITER:  cfg_q.max_iterations <= cfg_data[MAX_ITER_W-1:0];
				REG_VIEW_LEFT: cfg_q.view_left      <= cfg_data[COORD_W-1:0];
				REG_VIEW_TOP:  cfg_q.view_top       <= cfg_data[COORD_W-1:0];
				REG_STEP_REAL: cfg_q.step_real      <= cfg_data[STEP_W-1:0];
				REG_STEP_IMAG: cfg_q.step_imag      <= cfg_data[STEP_W-1:0];
				REG_PAL_OFF:   cfg_q.palette_offset <= cfg_data[PAL_OFF_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// The idle step of the program is the only one that takes a request.
	assign in_ready = ctl.take_in;
	assign in_fire  = in_valid && in_ready;

	// The output register is busy while it holds a result that is not taken this cycle.
	assign out_busy = out_valid_q && !out_ready;
	assign out_load = ctl.load_out && !out_busy;

	always_comb begin
		cond.no_req   = !in_valid;
		cond.stop     = dp_stop;
		cond.out_busy = out_busy;
	end

	mbe_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.cond   (cond),
		.ctl    (ctl)
	);

	mbe_datapath #(
		.FRAC_BITS (FRAC_BITS)
	) u_datapath (
		.clk     (clk),
		.ctl     (ctl),
		.in_fire (in_fire),
		.in_item (in_data),
		.cfg     (cfg_q),
		.stop    (dp_stop),
		.result  (dp_result)
	);

	// A new result is loaded only when the previous one is gone or leaves this cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= dp_result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule
